// ----- design/dcwr_pkg.sv -----
// ----------------------------------------------------------------------------
// dcwr_pkg
// Shared types, constants and helpers of the cycle-weighted DAC resampler.
// ----------------------------------------------------------------------------
package dcwr_pkg;

    // field widths
    localparam int CYC_W   = 20;
    localparam int SPU_W   = 16;
    localparam int LVL_W   = 8;
    localparam int SMP_W   = 16;
    localparam int SUM_W   = 28;
    localparam int PROD_W  = CYC_W + SPU_W;
    localparam int NUM_W   = SUM_W + 1;
    localparam int DVD_W   = PROD_W + 1;
    localparam int STEP_W  = 6;
    localparam int CFG_W   = 20;

    // divider step counts
    localparam logic [STEP_W-1:0] TOTAL_STEPS = STEP_W'(DVD_W);
    localparam logic [STEP_W-1:0] SUM_STEPS   = STEP_W'(NUM_W);

    // reset values of the configuration registers
    localparam logic [CYC_W-1:0] RST_CYCLES_PER_UNIT  = 20'd20000;
    localparam logic [SPU_W-1:0] RST_SAMPLES_PER_UNIT = 16'd147;
    localparam logic [CYC_W-1:0] RST_FRAME_CYCLES     = 20'd119808;
    localparam logic             RST_STEREO           = 1'b1;

    localparam logic [LVL_W-1:0] SILENCE = 8'h80;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_CYCLES_PER_UNIT  = 2'd0,
        CFG_SAMPLES_PER_UNIT = 2'd1,
        CFG_FRAME_CYCLES     = 2'd2,
        CFG_STEREO           = 2'd3
    } t_cfg_idx;

    // operation codes of an input word
    typedef enum logic [1:0] {
        OP_WRITE_LEFT  = 2'd0,
        OP_WRITE_RIGHT = 2'd1,
        OP_WRITE_BOTH  = 2'd2,
        OP_FRAME_END   = 2'd3
    } t_op;

    // divider dividend source
    typedef enum logic [1:0] {
        DIV_TOTAL = 2'd0,
        DIV_LEFT  = 2'd1,
        DIV_RIGHT = 2'd2
    } t_div_sel;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_POS,
        S_TOTAL_START,
        S_TOTAL_WAIT,
        S_EVAL,
        S_ACC_MUL,
        S_ACC_ADD,
        S_SPAN_MUL,
        S_LEFT_START,
        S_LEFT_WAIT,
        S_RIGHT_START,
        S_RIGHT_WAIT,
        S_EMIT,
        S_COMMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic     load_item;
        logic     mul_pos;
        logic     mul_carry;
        logic     div_start;
        t_div_sel div_sel;
        logic     cap_total;
        logic     cap_left;
        logic     cap_right;
        logic     acc_mul;
        logic     acc_add;
        logic     span_mul;
        logic     emit;
        logic     commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic n_zero;
        logic acc_needed;
        logic out_free;
    } t_status;

    // offset binary byte to signed 16-bit sample, byte repeated in both halves
    function automatic logic [SMP_W-1:0] f_to_sample(input logic [LVL_W-1:0] b);
        logic [LVL_W-1:0] s;
        s = b ^ SILENCE;
        return {s, s};
    endfunction

endpackage

// ----- design/dcwr_div.sv -----
// ----------------------------------------------------------------------------
// dcwr_div
// Restoring radix-2 divider, one quotient bit per cycle. The dividend is
// given left-aligned; after i_steps steps the low bits hold the quotient.
// ----------------------------------------------------------------------------
module dcwr_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [dcwr_pkg::DVD_W-1:0]     i_dividend,
    input  logic [dcwr_pkg::CYC_W-1:0]     i_divisor,
    input  logic [dcwr_pkg::STEP_W-1:0]    i_steps,
    output logic                           o_done,
    output logic [dcwr_pkg::DVD_W-1:0]     o_quot,
    output logic [dcwr_pkg::CYC_W-1:0]     o_rem
);

    logic [dcwr_pkg::DVD_W-1:0]  r_quot;
    logic [dcwr_pkg::CYC_W-1:0]  r_rem;
    logic [dcwr_pkg::STEP_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;

    logic [dcwr_pkg::CYC_W:0]    w_trial;
    logic [dcwr_pkg::CYC_W:0]    w_diff;
    logic                        w_ge;

    // trial subtract of one step
    always_comb begin
        w_trial = {r_rem, r_quot[dcwr_pkg::DVD_W-1]};
        w_ge    = (w_trial >= {1'b0, i_divisor});
        w_diff  = w_trial - {1'b0, i_divisor};
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == dcwr_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_quot <= {r_quot[dcwr_pkg::DVD_W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[dcwr_pkg::CYC_W-1:0] : w_trial[dcwr_pkg::CYC_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ----- design/dcwr_datapath.sv -----
// ----------------------------------------------------------------------------
// dcwr_datapath
// Configuration, resampler state, multipliers, shared divider and the
// output register of the cycle-weighted DAC resampler.
// ----------------------------------------------------------------------------
module dcwr_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dcwr_pkg::t_cmd                i_cmd,
    output dcwr_pkg::t_status             o_status,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [dcwr_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic [1:0]                    i_operation,
    input  logic [dcwr_pkg::LVL_W-1:0]    i_level,
    input  logic [dcwr_pkg::CYC_W-1:0]    i_cycle_pos,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dcwr_pkg::SMP_W-1:0]    o_first_left,
    output logic [dcwr_pkg::SMP_W-1:0]    o_first_right,
    output logic [dcwr_pkg::SMP_W-1:0]    o_fill_left,
    output logic [dcwr_pkg::SMP_W-1:0]    o_fill_right,
    output logic [dcwr_pkg::SMP_W-1:0]    o_fill_count
);

    // configuration
    logic [dcwr_pkg::CYC_W-1:0] r_cycles_per_unit;
    logic [dcwr_pkg::SPU_W-1:0] r_samples_per_unit;
    logic [dcwr_pkg::CYC_W-1:0] r_frame_cycles;
    logic                       r_stereo;

    // resampler state
    logic [dcwr_pkg::LVL_W-1:0] r_left_level;
    logic [dcwr_pkg::LVL_W-1:0] r_right_level;
    logic [dcwr_pkg::SUM_W-1:0] r_left_sum;
    logic [dcwr_pkg::SUM_W-1:0] r_right_sum;
    logic [dcwr_pkg::CYC_W-1:0] r_last_phase;
    logic [dcwr_pkg::CYC_W-1:0] r_phase_carry;
    logic [dcwr_pkg::SMP_W-1:0] r_samples_done;

    // working registers of one word
    logic [1:0]                  r_op;
    logic [dcwr_pkg::LVL_W-1:0]  r_level;
    logic [dcwr_pkg::CYC_W-1:0]  r_pos;
    logic [dcwr_pkg::CYC_W-1:0]  r_div;
    logic [dcwr_pkg::PROD_W-1:0] r_prod;
    logic [dcwr_pkg::SMP_W-1:0]  r_sofar;
    logic [dcwr_pkg::CYC_W-1:0]  r_period;
    logic [dcwr_pkg::SUM_W-1:0]  r_lprod;
    logic [dcwr_pkg::SUM_W-1:0]  r_rprod;
    logic [dcwr_pkg::LVL_W-1:0]  r_fl;
    logic [dcwr_pkg::LVL_W-1:0]  r_fr;

    // output register
    logic                        r_out_valid;
    logic [dcwr_pkg::SMP_W-1:0]  r_first_left;
    logic [dcwr_pkg::SMP_W-1:0]  r_first_right;
    logic [dcwr_pkg::SMP_W-1:0]  r_fill_left;
    logic [dcwr_pkg::SMP_W-1:0]  r_fill_right;
    logic [dcwr_pkg::SMP_W-1:0]  r_fill_count;

    logic [dcwr_pkg::CYC_W-1:0]  w_pos_in;
    logic [dcwr_pkg::CYC_W-1:0]  w_div_in;
    logic [dcwr_pkg::CYC_W-1:0]  w_mul_a;
    logic [dcwr_pkg::PROD_W-1:0] w_prod;
    logic [dcwr_pkg::CYC_W-1:0]  w_delta;
    logic [dcwr_pkg::CYC_W-1:0]  w_span;
    logic [dcwr_pkg::CYC_W-1:0]  w_lvl_x;
    logic [dcwr_pkg::SUM_W-1:0]  w_lprod;
    logic [dcwr_pkg::SUM_W-1:0]  w_rprod;
    logic [dcwr_pkg::DVD_W-1:0]  w_total;
    logic [dcwr_pkg::NUM_W-1:0]  w_left_num;
    logic [dcwr_pkg::NUM_W-1:0]  w_right_num;
    logic [dcwr_pkg::DVD_W-1:0]  w_dividend;
    logic [dcwr_pkg::STEP_W-1:0] w_steps;
    logic [dcwr_pkg::LVL_W:0]    w_first_mix;
    logic [dcwr_pkg::LVL_W:0]    w_fill_mix;
    logic [dcwr_pkg::SMP_W-1:0]  w_sofar_sat;
    logic [dcwr_pkg::CYC_W-1:0]  w_carry_next;
    logic                        w_div_done;
    logic [dcwr_pkg::DVD_W-1:0]  w_quot;
    logic [dcwr_pkg::CYC_W-1:0]  w_rem;

    // clamp position, guard divisor against zero
    always_comb begin
        w_pos_in = (i_cycle_pos < r_frame_cycles) ? i_cycle_pos : r_frame_cycles;
        w_div_in = (r_cycles_per_unit == '0) ? dcwr_pkg::CYC_W'(1) : r_cycles_per_unit;
    end

    // ratio multiplier: position or frame remainder times samples per unit
    always_comb begin
        w_mul_a = i_cmd.mul_pos ? r_pos : (r_frame_cycles - r_pos);
        w_prod  = dcwr_pkg::PROD_W'(w_mul_a) * dcwr_pkg::PROD_W'(r_samples_per_unit);
    end

    // level weighting multipliers
    always_comb begin
        w_delta = r_period - r_last_phase;
        w_span  = (r_div > r_last_phase) ? (r_div - r_last_phase) : '0;
        if (i_cmd.acc_mul) begin
            w_lvl_x = w_delta;
        end else if (i_cmd.span_mul) begin
            w_lvl_x = w_span;
        end else begin
            w_lvl_x = r_period;
        end
        w_lprod = dcwr_pkg::SUM_W'(r_left_level) * dcwr_pkg::SUM_W'(w_lvl_x);
        w_rprod = dcwr_pkg::SUM_W'(r_right_level) * dcwr_pkg::SUM_W'(w_lvl_x);
    end

    // divider operand select
    always_comb begin
        w_total     = dcwr_pkg::DVD_W'(r_prod) + dcwr_pkg::DVD_W'(r_phase_carry);
        w_left_num  = dcwr_pkg::NUM_W'(r_left_sum) + dcwr_pkg::NUM_W'(r_lprod);
        w_right_num = dcwr_pkg::NUM_W'(r_right_sum) + dcwr_pkg::NUM_W'(r_rprod);
        case (i_cmd.div_sel)
            dcwr_pkg::DIV_TOTAL: begin
                w_dividend = w_total;
                w_steps    = dcwr_pkg::TOTAL_STEPS;
            end
            dcwr_pkg::DIV_LEFT: begin
                w_dividend = {w_left_num, {(dcwr_pkg::DVD_W - dcwr_pkg::NUM_W){1'b0}}};
                w_steps    = dcwr_pkg::SUM_STEPS;
            end
            dcwr_pkg::DIV_RIGHT: begin
                w_dividend = {w_right_num, {(dcwr_pkg::DVD_W - dcwr_pkg::NUM_W){1'b0}}};
                w_steps    = dcwr_pkg::SUM_STEPS;
            end
            default: begin
                w_dividend = w_total;
                w_steps    = dcwr_pkg::TOTAL_STEPS;
            end
        endcase
    end

    dcwr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_div),
        .i_steps    (w_steps),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // sample count saturates at the 16-bit limit
    assign w_sofar_sat = (|w_quot[dcwr_pkg::DVD_W-1:dcwr_pkg::SMP_W]) ? '1
                                                                       : w_quot[dcwr_pkg::SMP_W-1:0];

    // mono mixes and carried phase
    always_comb begin
        w_first_mix  = ({1'b0, r_fl} + {1'b0, r_fr}) >> 1;
        w_fill_mix   = ({1'b0, r_left_level} + {1'b0, r_right_level}) >> 1;
        w_carry_next = r_period + r_prod[dcwr_pkg::CYC_W-1:0];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycles_per_unit  <= dcwr_pkg::RST_CYCLES_PER_UNIT;
            r_samples_per_unit <= dcwr_pkg::RST_SAMPLES_PER_UNIT;
            r_frame_cycles     <= dcwr_pkg::RST_FRAME_CYCLES;
            r_stereo           <= dcwr_pkg::RST_STEREO;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dcwr_pkg::CFG_CYCLES_PER_UNIT:  r_cycles_per_unit  <= i_cfg_data;
                dcwr_pkg::CFG_SAMPLES_PER_UNIT:
                    r_samples_per_unit <= i_cfg_data[dcwr_pkg::SPU_W-1:0];
                dcwr_pkg::CFG_FRAME_CYCLES:     r_frame_cycles     <= i_cfg_data;
                dcwr_pkg::CFG_STEREO:           r_stereo           <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // resampler state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_level   <= dcwr_pkg::SILENCE;
            r_right_level  <= dcwr_pkg::SILENCE;
            r_left_sum     <= '0;
            r_right_sum    <= '0;
            r_last_phase   <= '0;
            r_phase_carry  <= '0;
            r_samples_done <= '0;
        end else begin
            if (i_cmd.acc_add) begin
                r_left_sum  <= r_left_sum + r_lprod;
                r_right_sum <= r_right_sum + r_rprod;
            end else if (i_cmd.emit) begin
                r_left_sum  <= w_lprod;
                r_right_sum <= w_rprod;
            end
            if (i_cmd.commit) begin
                r_last_phase <= r_period;
                if (r_op == dcwr_pkg::OP_FRAME_END) begin
                    r_phase_carry  <= w_carry_next;
                    r_samples_done <= '0;
                end else begin
                    r_samples_done <= r_sofar;
                    if (r_op == dcwr_pkg::OP_WRITE_LEFT || r_op == dcwr_pkg::OP_WRITE_BOTH) begin
                        r_left_level <= r_level;
                    end
                    if (r_op == dcwr_pkg::OP_WRITE_RIGHT || r_op == dcwr_pkg::OP_WRITE_BOTH) begin
                        r_right_level <= r_level;
                    end
                end
            end
        end
    end

    // per-word working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op    <= i_operation;
            r_level <= i_level;
            r_pos   <= w_pos_in;
            r_div   <= w_div_in;
        end
        if (i_cmd.mul_pos || i_cmd.mul_carry) begin
            r_prod <= w_prod;
        end
        if (i_cmd.cap_total) begin
            r_sofar  <= w_sofar_sat;
            r_period <= w_rem;
        end
        if (i_cmd.acc_mul || i_cmd.span_mul) begin
            r_lprod <= w_lprod;
            r_rprod <= w_rprod;
        end
        if (i_cmd.cap_left) begin
            r_fl <= w_quot[dcwr_pkg::LVL_W-1:0];
        end
        if (i_cmd.cap_right) begin
            r_fr <= w_quot[dcwr_pkg::LVL_W-1:0];
        end
    end

    // output word valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_stereo) begin
                r_first_left  <= dcwr_pkg::f_to_sample(r_fl);
                r_first_right <= dcwr_pkg::f_to_sample(r_fr);
                r_fill_left   <= dcwr_pkg::f_to_sample(r_left_level);
                r_fill_right  <= dcwr_pkg::f_to_sample(r_right_level);
            end else begin
                r_first_left  <= dcwr_pkg::f_to_sample(w_first_mix[dcwr_pkg::LVL_W-1:0]);
                r_first_right <= dcwr_pkg::f_to_sample(w_first_mix[dcwr_pkg::LVL_W-1:0]);
                r_fill_left   <= dcwr_pkg::f_to_sample(w_fill_mix[dcwr_pkg::LVL_W-1:0]);
                r_fill_right  <= dcwr_pkg::f_to_sample(w_fill_mix[dcwr_pkg::LVL_W-1:0]);
            end
            r_fill_count <= r_sofar - r_samples_done - dcwr_pkg::SMP_W'(1);
        end
    end

    // status back to the controller
    always_comb begin
        o_status.div_done   = w_div_done;
        o_status.n_zero     = (r_sofar <= r_samples_done);
        o_status.acc_needed = (r_period > r_last_phase);
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_first_left  = r_first_left;
    assign o_first_right = r_first_right;
    assign o_fill_left   = r_fill_left;
    assign o_fill_right  = r_fill_right;
    assign o_fill_count  = r_fill_count;

endmodule

// ----- design/dcwr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dcwr_ctrl
// Sequencer of the resampler: steps one input word through the ratio
// multiply, the phase division, accumulation or mean divisions and commit.
// ----------------------------------------------------------------------------
module dcwr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dcwr_pkg::t_status   i_status,
    output dcwr_pkg::t_cmd      o_cmd
);

    dcwr_pkg::t_state r_state;
    dcwr_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcwr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.div_sel = dcwr_pkg::DIV_TOTAL;
        o_in_ready    = 1'b0;
        case (r_state)
            dcwr_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = dcwr_pkg::S_MUL_POS;
                end
            end
            dcwr_pkg::S_MUL_POS: begin
                o_cmd.mul_pos = 1'b1;
                n_state       = dcwr_pkg::S_TOTAL_START;
            end
            dcwr_pkg::S_TOTAL_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = dcwr_pkg::DIV_TOTAL;
                n_state         = dcwr_pkg::S_TOTAL_WAIT;
            end
            dcwr_pkg::S_TOTAL_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.cap_total = 1'b1;
                    n_state         = dcwr_pkg::S_EVAL;
                end
            end
            dcwr_pkg::S_EVAL: begin
                // frame carry product is formed here for every word
                o_cmd.mul_carry = 1'b1;
                if (!i_status.n_zero) begin
                    n_state = dcwr_pkg::S_SPAN_MUL;
                end else if (i_status.acc_needed) begin
                    n_state = dcwr_pkg::S_ACC_MUL;
                end else begin
                    n_state = dcwr_pkg::S_COMMIT;
                end
            end
            dcwr_pkg::S_ACC_MUL: begin
                o_cmd.acc_mul = 1'b1;
                n_state       = dcwr_pkg::S_ACC_ADD;
            end
            dcwr_pkg::S_ACC_ADD: begin
                o_cmd.acc_add = 1'b1;
                n_state       = dcwr_pkg::S_COMMIT;
            end
            dcwr_pkg::S_SPAN_MUL: begin
                o_cmd.span_mul = 1'b1;
                n_state        = dcwr_pkg::S_LEFT_START;
            end
            dcwr_pkg::S_LEFT_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = dcwr_pkg::DIV_LEFT;
                n_state         = dcwr_pkg::S_LEFT_WAIT;
            end
            dcwr_pkg::S_LEFT_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.cap_left = 1'b1;
                    n_state        = dcwr_pkg::S_RIGHT_START;
                end
            end
            dcwr_pkg::S_RIGHT_START: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = dcwr_pkg::DIV_RIGHT;
                n_state         = dcwr_pkg::S_RIGHT_WAIT;
            end
            dcwr_pkg::S_RIGHT_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.cap_right = 1'b1;
                    n_state         = dcwr_pkg::S_EMIT;
                end
            end
            dcwr_pkg::S_EMIT: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = dcwr_pkg::S_COMMIT;
                end
            end
            dcwr_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = dcwr_pkg::S_IDLE;
            end
            default: begin
                n_state = dcwr_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- design/dac_cycle_weighted_resampler.sv -----
// ----------------------------------------------------------------------------
// dac_cycle_weighted_resampler
// Turns timed 8-bit DAC level writes into runs of 16-bit output samples.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) carries one word: an operation
// (write left, write right, write both, frame end), a level and the cycle
// position in the frame. Output channel (o_out_valid / i_out_ready) carries
// one word per event that completes at least one sample: the weighted first
// sample, the fill sample and the fill count. Configuration is written
// through i_cfg_we / i_cfg_index / i_cfg_data; the user must write it
// only while the block is idle, which the block itself does not enforce.
// One word at a time is processed: the next word is taken only after the
// current one commits. The work on each word is paced by the shared
// one-bit-per-cycle divider: 37 steps for the phase, then, for a word that
// completes samples, 29 steps for each channel's mean.
// The output register holds a result while the receiver stalls; the next
// word is still taken and worked on, and only its own result waits.
// Synchronous reset restores the configuration defaults, silence levels
// and cleared sums and phase; no result is pending after reset.
// ----------------------------------------------------------------------------
module dac_cycle_weighted_resampler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [dcwr_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_operation,
    input  logic [dcwr_pkg::LVL_W-1:0]    i_level,
    input  logic [dcwr_pkg::CYC_W-1:0]    i_cycle_pos,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dcwr_pkg::SMP_W-1:0]    o_first_left,
    output logic [dcwr_pkg::SMP_W-1:0]    o_first_right,
    output logic [dcwr_pkg::SMP_W-1:0]    o_fill_left,
    output logic [dcwr_pkg::SMP_W-1:0]    o_fill_right,
    output logic [dcwr_pkg::SMP_W-1:0]    o_fill_count
);

    dcwr_pkg::t_cmd    w_cmd;
    dcwr_pkg::t_status w_status;

    // sequencer
    dcwr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath
    dcwr_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_operation   (i_operation),
        .i_level       (i_level),
        .i_cycle_pos   (i_cycle_pos),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_first_left  (o_first_left),
        .o_first_right (o_first_right),
        .o_fill_left   (o_fill_left),
        .o_fill_right  (o_fill_right),
        .o_fill_count  (o_fill_count)
    );

`ifndef SYNTHESIS
    // one word in flight: no second acceptance right after the first
    a_single_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word is in flight");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result emitted over a stalled result");

    // a new result only follows an emit command
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.emit))
        else $error("output valid rose without emit");

    // divider results are captured by one consumer at a time
    a_one_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.cap_total, w_cmd.cap_left, w_cmd.cap_right}))
        else $error("divider result captured twice");
`endif

endmodule

// ----- tb/dcwr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcwr_checker
// Watches the channels of the DAC resampler, predicts and compares results.
// ----------------------------------------------------------------------------
// Keeps its own copy of the configuration registers and of the level, sum,
// phase and sample-count state. Every accepted input word advances the
// predicted timeline; a word that completes samples queues one expected
// sample run. Every accepted output word is checked field by field against
// the oldest queued run.
// ----------------------------------------------------------------------------
module dcwr_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [dcwr_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [1:0]                    i_operation,
    input  logic [dcwr_pkg::LVL_W-1:0]    i_level,
    input  logic [dcwr_pkg::CYC_W-1:0]    i_cycle_pos,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [dcwr_pkg::SMP_W-1:0]    i_first_left,
    input  logic [dcwr_pkg::SMP_W-1:0]    i_first_right,
    input  logic [dcwr_pkg::SMP_W-1:0]    i_fill_left,
    input  logic [dcwr_pkg::SMP_W-1:0]    i_fill_right,
    input  logic [dcwr_pkg::SMP_W-1:0]    i_fill_count,
    output int                            o_pending,
    output int                            o_errors
);
    import dcwr_pkg::*;

    localparam logic [63:0] SAMPLE_CEILING = 64'd65535;

    typedef struct packed {
        logic [SMP_W-1:0] first_left;
        logic [SMP_W-1:0] first_right;
        logic [SMP_W-1:0] fill_left;
        logic [SMP_W-1:0] fill_right;
        logic [SMP_W-1:0] fill_count;
    } t_sample_run;

    // shadow configuration
    logic [CYC_W-1:0] cfg_cycles_per_unit;
    logic [SPU_W-1:0] cfg_samples_per_unit;
    logic [CYC_W-1:0] cfg_frame_cycles;
    logic             cfg_stereo;

    // shadow timeline state
    logic [LVL_W-1:0] left_lvl;
    logic [LVL_W-1:0] right_lvl;
    logic [SUM_W-1:0] left_acc;
    logic [SUM_W-1:0] right_acc;
    logic [CYC_W-1:0] last_ph;
    logic [CYC_W-1:0] phase_carry;
    logic [15:0]      samples_out;

    t_sample_run expected_runs_q[$];
    int          mismatch_count = 0;

    assign o_errors = mismatch_count;

    // offset binary byte to pcm, signed byte in both halves
    function automatic logic [SMP_W-1:0] level_to_pcm(input logic [LVL_W-1:0] b);
        logic [LVL_W-1:0] centered;
        centered = b - 8'h80;
        return {centered, centered};
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 40)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input logic [SMP_W-1:0] got,
                                 input logic [SMP_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic clear_shadow();
        cfg_cycles_per_unit  = RST_CYCLES_PER_UNIT;
        cfg_samples_per_unit = RST_SAMPLES_PER_UNIT;
        cfg_frame_cycles     = RST_FRAME_CYCLES;
        cfg_stereo           = RST_STEREO;
        left_lvl    = 8'h80;
        right_lvl   = 8'h80;
        left_acc    = '0;
        right_acc   = '0;
        last_ph     = '0;
        phase_carry = '0;
        samples_out = '0;
    endtask

    // advance time to the word's position, then apply the level write or frame end
    task automatic predict_event(input t_op op, input logic [LVL_W-1:0] lvl,
                                 input logic [CYC_W-1:0] cpos);
        logic [63:0]      pos;
        logic [63:0]      divisor;
        logic [63:0]      total;
        logic [63:0]      sofar;
        logic [63:0]      period;
        logic [63:0]      span;
        logic [63:0]      wide;
        logic [LVL_W-1:0] mean_l;
        logic [LVL_W-1:0] mean_r;
        logic [LVL_W-1:0] mono_first;
        logic [LVL_W-1:0] mono_fill;
        t_sample_run      run;

        pos     = (cpos < cfg_frame_cycles) ? 64'(cpos) : 64'(cfg_frame_cycles);
        divisor = (cfg_cycles_per_unit == '0) ? 64'd1 : 64'(cfg_cycles_per_unit);
        total   = pos * 64'(cfg_samples_per_unit) + 64'(phase_carry);
        sofar   = total / divisor;
        period  = total % divisor;
        if (sofar > SAMPLE_CEILING)
            sofar = SAMPLE_CEILING;
        // time went backward across samples
        if (64'(samples_out) > sofar)
            samples_out = sofar[15:0];

        if (sofar == 64'(samples_out)) begin
            // still inside one sample: weight levels by cycles held
            if (period > 64'(last_ph)) begin
                wide = 64'(left_acc) + 64'(left_lvl) * (period - 64'(last_ph));
                left_acc = wide[SUM_W-1:0];
                wide = 64'(right_acc) + 64'(right_lvl) * (period - 64'(last_ph));
                right_acc = wide[SUM_W-1:0];
            end
        end else begin
            span = (divisor > 64'(last_ph)) ? divisor - 64'(last_ph) : 64'd0;
            wide = (64'(left_acc) + 64'(left_lvl) * span) / divisor;
            mean_l = wide[7:0];
            wide = (64'(right_acc) + 64'(right_lvl) * span) / divisor;
            mean_r = wide[7:0];
            if (cfg_stereo) begin
                run.first_left  = level_to_pcm(mean_l);
                run.first_right = level_to_pcm(mean_r);
                run.fill_left   = level_to_pcm(left_lvl);
                run.fill_right  = level_to_pcm(right_lvl);
            end else begin
                mono_first = 8'(({1'b0, mean_l} + {1'b0, mean_r}) >> 1);
                mono_fill  = 8'(({1'b0, left_lvl} + {1'b0, right_lvl}) >> 1);
                run.first_left  = level_to_pcm(mono_first);
                run.first_right = run.first_left;
                run.fill_left   = level_to_pcm(mono_fill);
                run.fill_right  = run.fill_left;
            end
            wide = sofar - 64'(samples_out) - 64'd1;
            run.fill_count = wide[15:0];
            expected_runs_q.push_back(run);
            // restart sums with the part of the new sample already elapsed
            wide = 64'(left_lvl) * period;
            left_acc = wide[SUM_W-1:0];
            wide = 64'(right_lvl) * period;
            right_acc = wide[SUM_W-1:0];
        end

        last_ph     = period[CYC_W-1:0];
        samples_out = sofar[15:0];

        case (op)
            OP_FRAME_END: begin
                wide = period + (64'(cfg_frame_cycles) - pos) * 64'(cfg_samples_per_unit);
                phase_carry = wide[CYC_W-1:0];
                samples_out = '0;
            end
            OP_WRITE_LEFT:  left_lvl = lvl;
            OP_WRITE_RIGHT: right_lvl = lvl;
            default: begin
                left_lvl  = lvl;
                right_lvl = lvl;
            end
        endcase
    endtask

    task automatic check_run();
        t_sample_run want;
        if (expected_runs_q.size() == 0) begin
            report_mismatch($sformatf("result word with none expected, count %h",
                                      i_fill_count));
        end else begin
            want = expected_runs_q.pop_front();
            compare_field("first_left", i_first_left, want.first_left);
            compare_field("first_right", i_first_right, want.first_right);
            compare_field("fill_left", i_fill_left, want.fill_left);
            compare_field("fill_right", i_fill_right, want.fill_right);
            compare_field("fill_count", i_fill_count, want.fill_count);
        end
    endtask

    // sample both channels and the register port at each edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_shadow();
            expected_runs_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_CYCLES_PER_UNIT:  cfg_cycles_per_unit  = i_cfg_data[CYC_W-1:0];
                    CFG_SAMPLES_PER_UNIT: cfg_samples_per_unit = i_cfg_data[SPU_W-1:0];
                    CFG_FRAME_CYCLES:     cfg_frame_cycles     = i_cfg_data[CYC_W-1:0];
                    default:              cfg_stereo           = i_cfg_data[0];
                endcase
            end
            if (i_out_valid && i_out_ready)
                check_run();
            if (i_in_valid && i_in_ready)
                predict_event(t_op'(i_operation), i_level, i_cycle_pos);
        end
        o_pending <= expected_runs_q.size();
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the cycle-weighted DAC resampler.
// ----------------------------------------------------------------------------
// A short directed sequence runs on the reset configuration, then several
// phases each program all four registers (extremes included) and stream
// frames of level writes at rising cycle positions ending in a frame end,
// mixed with random noise words. Sender gaps and receiver stalls vary by
// phase, and one phase holds the receiver off long enough to back up the
// input. The checker beside the block predicts and compares every word.
// ----------------------------------------------------------------------------
module testbench;
    import dcwr_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 150;
    localparam int HOLD_CYCLES = 800;
    localparam int PHASE_WORDS = 84;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } t_idle_mode;

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_index = CFG_CYCLES_PER_UNIT;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [1:0]           i_operation = OP_WRITE_LEFT;
    logic [LVL_W-1:0]     i_level = '0;
    logic [CYC_W-1:0]     i_cycle_pos = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [SMP_W-1:0]     o_first_left;
    logic [SMP_W-1:0]     o_first_right;
    logic [SMP_W-1:0]     o_fill_left;
    logic [SMP_W-1:0]     o_fill_right;
    logic [SMP_W-1:0]     o_fill_count;

    int                   runs_pending;
    int                   error_count;
    int                   cycle_count = 0;
    t_idle_mode           idle_mode = IDLE_NONE;
    int                   hold_asked = 0;
    int                   hold_served = 0;
    int                   hold_left = 0;

    // configuration as last programmed, used to shape positions
    int unsigned          cur_cpu = 20000;
    int unsigned          cur_spu = 147;
    int unsigned          cur_frame = 119808;

    dac_cycle_weighted_resampler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_level       (i_level),
        .i_cycle_pos   (i_cycle_pos),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_first_left  (o_first_left),
        .o_first_right (o_first_right),
        .o_fill_left   (o_fill_left),
        .o_fill_right  (o_fill_right),
        .o_fill_count  (o_fill_count)
    );

    dcwr_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_level       (i_level),
        .i_cycle_pos   (i_cycle_pos),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_first_left  (o_first_left),
        .i_first_right (o_first_right),
        .i_fill_left   (o_fill_left),
        .i_fill_right  (o_fill_right),
        .i_fill_count  (o_fill_count),
        .o_pending     (runs_pending),
        .o_errors      (error_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dac_cycle_weighted_resampler test failed");
            $finish;
        end
    end

    // receiver: random stalls per phase, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            hold_served <= hold_asked;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECEIVER: i_out_ready <= ($urandom_range(0, 99) >= 62);
                IDLE_BOTH:     i_out_ready <= ($urandom_range(0, 99) >= 9);
                default:       i_out_ready <= 1'b1;
            endcase
        end
    end

    // offer one input word and hold it until taken
    task automatic send_word(input t_op op, input logic [LVL_W-1:0] lvl,
                             input logic [CYC_W-1:0] pos);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER) ? 62 : (idle_mode == IDLE_BOTH) ? 9 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_level     <= lvl;
        i_cycle_pos <= pos;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
    endtask

    // stop offering, wait for every expected word, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (runs_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(input int unsigned cpu, input int unsigned spu,
                                input int unsigned frame, input int unsigned stereo);
        t_cfg_idx              idx [4];
        logic [CFG_W-1:0]      val [4];
        idx[0] = CFG_CYCLES_PER_UNIT;  val[0] = CFG_W'(cpu);
        idx[1] = CFG_SAMPLES_PER_UNIT; val[1] = CFG_W'(spu);
        idx[2] = CFG_FRAME_CYCLES;     val[2] = CFG_W'(frame);
        idx[3] = CFG_STEREO;           val[3] = CFG_W'(stereo);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= val[i];
            @(posedge i_clk);
        end
        i_cfg_we  <= 1'b0;
        cur_cpu   = cpu;
        cur_spu   = spu;
        cur_frame = frame;
    endtask

    // frames of rising-position writes closed by a frame end, plus noise words
    task automatic stream_frames(input int words);
        int          sent;
        int unsigned per_sample;
        int unsigned step_cap;
        int unsigned pos;
        int unsigned writes;
        int unsigned pick;
        logic [7:0]  lvl;
        sent = 0;
        while (sent < words) begin
            if ($urandom_range(0, 99) < 15) begin
                send_word(t_op'($urandom_range(0, 3)), 8'($urandom), 20'($urandom));
                sent++;
            end else begin
                per_sample = cur_cpu / ((cur_spu == 0) ? 1 : cur_spu) + 1;
                pick = $urandom_range(0, 2);
                step_cap = (pick == 0) ? per_sample / 2 + 1 :
                           (pick == 1) ? per_sample * 3 + 1 : cur_frame / 8 + 1;
                pos = $urandom_range(0, step_cap);
                writes = $urandom_range(1, 10);
                repeat (writes) begin
                    if ($urandom_range(0, 7) == 0)
                        lvl = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                    else
                        lvl = 8'($urandom);
                    send_word(t_op'($urandom_range(0, 2)), lvl,
                              (pos > 32'hFFFFF) ? 20'hFFFFF : 20'(pos));
                    pos += $urandom_range(0, step_cap);
                    sent++;
                end
                pick = $urandom_range(0, 3);
                pos = (pick == 1) ? cur_frame + $urandom_range(0, 5000) :
                      (pick == 2) ? $urandom_range(0, cur_frame) : cur_frame;
                send_word(OP_FRAME_END, 8'($urandom),
                          (pos > 32'hFFFFF) ? 20'hFFFFF : 20'(pos));
                sent++;
            end
        end
    endtask

    task automatic run_phase(input int unsigned cpu, input int unsigned spu,
                             input int unsigned frame, input int unsigned stereo,
                             input t_idle_mode mode, input bit hold_off);
        program_regs(cpu, spu, frame, stereo);
        idle_mode <= mode;
        if (hold_off)
            hold_asked <= hold_asked + 1;
        stream_frames(PHASE_WORDS);
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words on the reset configuration
        send_word(OP_WRITE_LEFT, 8'hFF, 20'd0);
        send_word(OP_WRITE_RIGHT, 8'h00, 20'd50);
        send_word(OP_WRITE_BOTH, 8'h7F, 20'd100);
        send_word(OP_WRITE_LEFT, 8'h80, 20'd1000);
        // back in time within one sample, then across samples
        send_word(OP_WRITE_RIGHT, 8'hAA, 20'd990);
        send_word(OP_WRITE_BOTH, 8'h55, 20'd500);
        send_word(OP_WRITE_LEFT, 8'h01, 20'd5000);
        // position past frame end gets clamped
        send_word(OP_WRITE_RIGHT, 8'hFE, 20'hFFFFF);
        send_word(OP_FRAME_END, 8'h33, 20'hFFFFF);
        // frame end with nothing completed, carry wraps
        send_word(OP_FRAME_END, 8'hCC, 20'd0);
        send_word(OP_WRITE_BOTH, 8'hFF, 20'd7);
        send_word(OP_WRITE_LEFT, 8'h00, 20'd60000);
        send_word(OP_WRITE_RIGHT, 8'hFF, 20'd60001);
        send_word(OP_WRITE_BOTH, 8'h80, 20'd119808);
        send_word(OP_FRAME_END, 8'h00, 20'd119808);
        drain();

        // mono at the usual rate
        run_phase(20000, 147, 119808, 0, IDLE_SENDER, 1'b0);
        // largest divisor, one sample per unit: long sums
        run_phase(1048575, 1, 1048575, 1, IDLE_RECEIVER, 1'b0);
        // divisor shrunk to one, sample count saturates
        run_phase(1, 65535, 1048575, 0, IDLE_BOTH, 1'b0);
        // zero divisor acts as one
        run_phase(0, 3, 1000, 1, IDLE_NONE, 1'b0);
        // shortest frame, largest ratio terms
        run_phase(1048575, 65535, 1, 0, IDLE_SENDER, 1'b0);
        // receiver held off while input keeps coming
        run_phase(3000, 441, 60000, 1, IDLE_NONE, 1'b1);
        run_phase($urandom_range(1, 40000), $urandom_range(1, 2000),
                  $urandom_range(1000, 300000), $urandom_range(0, 1), IDLE_BOTH, 1'b0);

        if (error_count == 0)
            $display("dac_cycle_weighted_resampler test passed");
        else
            $display("dac_cycle_weighted_resampler test failed");
        $finish;
    end

endmodule
